// ----- hw/rtl/apbl_pkg.sv -----
// Shared types and constants for the array-backed position list.
// Holds field widths, action and status codes, FSM states and the
// command and status structs between the controller and the datapath.
package apbl_pkg;

  // Storage size and derived widths
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ACT_W  = 4;
  localparam int ST_W   = 3;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Stream payload layout
  localparam int IN_RAW_W  = ACT_W + POS_W + VAL_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = ST_W + VAL_W + POS_W + POS_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int IN_POS_LSB = ACT_W;
  localparam int IN_VAL_LSB = ACT_W + POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_AT    = 4'd0,
    ACT_INS_FIRST = 4'd1,
    ACT_INS_LAST  = 4'd2,
    ACT_RM_AT     = 4'd3,
    ACT_MODIFY    = 4'd4,
    ACT_READ      = 4'd5,
    ACT_LOCATE    = 4'd6,
    ACT_RM_VALUE  = 4'd7,
    ACT_CLEAR     = 4'd8,
    ACT_FIRST     = 4'd9,
    ACT_LAST      = 4'd10,
    ACT_NEXT      = 4'd11,
    ACT_PREV      = 4'd12
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOADJ    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RUN,
    S_DRAIN,
    S_FINAL,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming transaction
    logic exec;    // run checks and the effects that need no memory pass
    logic run;     // issue one memory read and advance the pointer
    logic proc;    // consume the returned read data
    logic commit;  // final write and length update after a pass
    logic emit;    // load the output register
  } apbl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_loop;  // operation needs a pass over the memory
    logic last;       // current read is the last of the pass
    logic hit;        // locate found its match
    logic out_free;   // output register can take a result
  } apbl_sts_t;

endpackage

// ----- hw/rtl/array_backed_position_list.sv -----
// Ordered list of up to DEPTH (64) signed 32-bit values at positions 1..length,
// one operation per input transaction and exactly one result transaction for
// each. Operations that do not move data (read position queries, modify,
// clear, insert at the end, remove of the last entry, errors) go through
// accept, execute and load of the output register; a read adds a pass
// over its one entry. Insert and remove at a position shift the later
// entries through the entry memory at one entry per cycle; locate and
// remove-all scan up to length entries the same way, locate stopping at
// its first match. One operation is in flight at a time; the next one is
// accepted as soon as the result sits in the output register, even while
// that result still waits to be taken.
// Depends on apbl_pkg, apbl_ctrl and apbl_dpath.
module array_backed_position_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [3:0] action, [10:4] position, [42:11] item_value, [47:43] zero
  input  logic [apbl_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [2:0] status, [34:3] read_value, [41:35] found_position,
  // [48:42] list_length, [55:49] zero
  output logic [apbl_pkg::OUT_W-1:0] m_tdata
);
  import apbl_pkg::*;

  apbl_cmd_t cmd;
  apbl_sts_t sts;

  // Sequencer
  apbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memory, pointers and result path
  apbl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- hw/rtl/apbl_ctrl.sv -----
// Controller state machine for the array-backed position list.
// Sequences accept, execute, memory pass, commit and result hand-off.
// Depends on apbl_pkg.
module apbl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  apbl_pkg::apbl_sts_t sts,
  output apbl_pkg::apbl_cmd_t cmd
);
  import apbl_pkg::*;

  state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_loop ? S_RUN : S_DONE;
      end
      S_RUN: begin
        cmd.run  = 1'b1;
        cmd.proc = 1'b1;
        if (sts.hit) begin
          state_next = S_DONE;
        end else if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.proc   = 1'b1;
        state_next = sts.hit ? S_DONE : S_FINAL;
      end
      S_FINAL: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/apbl_dpath.sv -----
// Datapath for the array-backed position list: entry memory, length,
// pass pointers, result registers and the output register.
// Depends on apbl_pkg; driven by apbl_ctrl through apbl_cmd_t.
module apbl_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  apbl_pkg::apbl_cmd_t       cmd,
  output apbl_pkg::apbl_sts_t       sts,
  input  logic [apbl_pkg::IN_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [apbl_pkg::OUT_W-1:0] m_tdata
);
  import apbl_pkg::*;

  // Entry memory
  logic [VAL_W-1:0] mem [DEPTH];

  // Latched transaction
  logic [ACT_W-1:0] act_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  // List state and pass pointers
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rptr;
  logic [CNT_W-1:0] rend;
  logic [CNT_W-1:0] raddr_q;
  logic [CNT_W-1:0] tgt;
  logic [CNT_W-1:0] wptr;
  logic             up;
  logic             rvalid;
  logic [VAL_W-1:0] rd_data;

  // Result registers
  status_e          res_status;
  logic [VAL_W-1:0] res_rd;
  logic [POS_W-1:0] res_fp;

  // Compare views
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_m1;
  logic             empty;
  logic             full;
  logic             pos_ok;
  logic             is_ins;

  // Execute decision
  status_e          ex_st;
  logic [POS_W-1:0] ex_fp;
  logic             ex_loop;
  logic             ex_up;
  logic [CNT_W-1:0] ex_rs;
  logic [CNT_W-1:0] ex_re;
  logic [CNT_W-1:0] ex_tgt;
  logic             ex_we;
  logic [CNT_W-1:0] ex_wa;
  logic [CNT_W-1:0] ex_cnt;
  logic [CNT_W-1:0] ins_a;

  // Write port
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic             pv;
  logic             hit;
  logic             keep;

  assign pos_x  = CMP_W'(pos_q);
  assign cnt_x  = CMP_W'(cnt);
  assign pos_m1 = pos_x - 1'b1;
  assign empty  = (cnt == '0);
  assign full   = (cnt_x >= CMP_W'(DEPTH));
  assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign is_ins = (act_q == ACT_INS_AT) || (act_q == ACT_INS_FIRST) ||
                  (act_q == ACT_INS_LAST);

  // Insert slot: end of list, head, or the given position
  always_comb begin
    if (act_q == ACT_INS_LAST) begin
      ins_a = cnt;
    end else if ((act_q == ACT_INS_FIRST) || empty) begin
      ins_a = '0;
    end else begin
      ins_a = CNT_W'(pos_m1);
    end
  end

  // Decide status and the effects of the operation that need no memory pass
  always_comb begin
    ex_st   = ST_OK;
    ex_fp   = '0;
    ex_loop = 1'b0;
    ex_up   = 1'b1;
    ex_rs   = '0;
    ex_re   = '0;
    ex_tgt  = '0;
    ex_we   = 1'b0;
    ex_wa   = '0;
    ex_cnt  = cnt;
    case (act_q)
      ACT_INS_AT, ACT_INS_FIRST, ACT_INS_LAST: begin
        if (full) begin
          ex_st = ST_FULL;
        end else if ((act_q == ACT_INS_AT) && !empty && !pos_ok) begin
          ex_st = ST_RANGE;
        end else if (ins_a == cnt) begin
          ex_we  = 1'b1;
          ex_wa  = ins_a;
          ex_cnt = cnt + 1'b1;
        end else begin
          ex_loop = 1'b1;
          ex_up   = 1'b0;
          ex_rs   = cnt - 1'b1;
          ex_re   = ins_a;
          ex_tgt  = ins_a;
        end
      end
      ACT_RM_AT: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else if (!pos_ok) begin
          ex_st = ST_RANGE;
        end else if (pos_x == cnt_x) begin
          ex_cnt = cnt - 1'b1;
        end else begin
          ex_loop = 1'b1;
          ex_rs   = CNT_W'(pos_x);
          ex_re   = cnt - 1'b1;
        end
      end
      ACT_MODIFY: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else if (!pos_ok) begin
          ex_st = ST_RANGE;
        end else begin
          ex_we = 1'b1;
          ex_wa = CNT_W'(pos_m1);
        end
      end
      ACT_READ: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else if (!pos_ok) begin
          ex_st = ST_RANGE;
        end else begin
          ex_loop = 1'b1;
          ex_rs   = CNT_W'(pos_m1);
          ex_re   = CNT_W'(pos_m1);
        end
      end
      ACT_LOCATE: begin
        ex_st = ST_NOTFOUND;
        if (!empty) begin
          ex_loop = 1'b1;
          ex_re   = cnt - 1'b1;
        end
      end
      ACT_RM_VALUE: begin
        if (!empty) begin
          ex_loop = 1'b1;
          ex_re   = cnt - 1'b1;
        end
      end
      ACT_CLEAR: begin
        ex_cnt = '0;
      end
      ACT_FIRST: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else begin
          ex_fp = POS_W'(1);
        end
      end
      ACT_LAST: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else begin
          ex_fp = cnt_x[POS_W-1:0];
        end
      end
      ACT_NEXT: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else if (pos_x == cnt_x) begin
          ex_st = ST_NOADJ;
        end else if (!pos_ok) begin
          ex_st = ST_RANGE;
        end else begin
          ex_fp = pos_q + 1'b1;
        end
      end
      ACT_PREV: begin
        if (empty) begin
          ex_st = ST_EMPTY;
        end else if (pos_x == CMP_W'(1)) begin
          ex_st = ST_NOADJ;
        end else if (!pos_ok) begin
          ex_st = ST_RANGE;
        end else begin
          ex_fp = pos_q - 1'b1;
        end
      end
      default: begin
        ex_st = ST_OK;
      end
    endcase
  end

  // Returned read data during a pass
  assign pv   = cmd.proc && rvalid;
  assign hit  = pv && (act_q == ACT_LOCATE) && (rd_data == val_q);
  assign keep = pv && (act_q == ACT_RM_VALUE) && (rd_data != val_q);

  // Select the single memory write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_q;
    if (cmd.exec) begin
      wr_en   = ex_we;
      wr_addr = ex_wa;
    end else if (cmd.commit) begin
      wr_en   = is_ins;
      wr_addr = tgt;
    end else if (pv) begin
      wr_data = rd_data;
      if (is_ins) begin
        wr_en   = 1'b1;
        wr_addr = raddr_q + 1'b1;
      end else if (act_q == ACT_RM_AT) begin
        wr_en   = 1'b1;
        wr_addr = raddr_q - 1'b1;
      end else if (keep) begin
        wr_en   = 1'b1;
        wr_addr = wptr;
      end
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.run) begin
      rd_data <= mem[rptr[ADDR_W-1:0]];
    end
  end

  // Control state: length, read-valid flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rvalid <= cmd.run;
      if (cmd.exec) begin
        cnt <= ex_cnt;
      end else if (cmd.commit) begin
        if (is_ins) begin
          cnt <= cnt + 1'b1;
        end else if (act_q == ACT_RM_AT) begin
          cnt <= cnt - 1'b1;
        end else if (act_q == ACT_RM_VALUE) begin
          cnt <= wptr;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: transaction latch, pointers, results, output data
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= s_tdata[ACT_W-1:0];
      pos_q <= s_tdata[IN_POS_LSB +: POS_W];
      val_q <= s_tdata[IN_VAL_LSB +: VAL_W];
    end
    if (cmd.exec) begin
      res_status <= ex_st;
      res_fp     <= ex_fp;
      res_rd     <= '0;
      rptr       <= ex_rs;
      rend       <= ex_re;
      up         <= ex_up;
      tgt        <= ex_tgt;
      wptr       <= '0;
    end
    if (cmd.run) begin
      raddr_q <= rptr;
      rptr    <= up ? (rptr + 1'b1) : (rptr - 1'b1);
    end
    if (pv && (act_q == ACT_READ)) begin
      res_rd <= rd_data;
    end
    if (hit) begin
      res_status <= ST_OK;
      res_fp     <= raddr_q[POS_W-1:0] + 1'b1;
    end
    if (keep) begin
      wptr <= wptr + 1'b1;
    end
    if (cmd.emit) begin
      m_tdata <= OUT_W'({cnt_x[POS_W-1:0], res_fp, res_rd, res_status});
    end
  end

  assign sts.need_loop = ex_loop;
  assign sts.last      = (rptr == rend);
  assign sts.hit       = hit;
  assign sts.out_free  = !m_tvalid || m_tready;

`ifndef SYNTH
  // Length never exceeds the storage
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(cnt) <= CMP_W'(DEPTH))
    else $error("list length above storage depth");

  // Every read of a pass lies inside the current list
  a_rd_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> (rptr < cnt))
    else $error("pass read outside the list");

  // A committed insert grows the list by exactly one entry
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_ins) |=> (cnt == $past(cnt) + 1'b1))
    else $error("insert commit did not grow list by one");

  // Compaction write pointer never passes the list length
  a_wptr_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.proc && (act_q == ACT_RM_VALUE)) |-> (wptr <= cnt))
    else $error("remove-all write pointer past list length");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for array_backed_position_list: a list tracker class
// predicts every result from the accepted operations and checks the output stream.
// Depends on apbl_pkg and the array_backed_position_list RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import apbl_pkg::*;

  // Actions outside the defined set, expected to act as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd13;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;

  // Result field offsets in m_tdata
  localparam int OUT_RD_LSB  = ST_W;
  localparam int OUT_FP_LSB  = ST_W + VAL_W;
  localparam int OUT_LEN_LSB = ST_W + VAL_W + POS_W;

  typedef struct {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] found_pos;
    logic [POS_W-1:0] list_len;
  } list_reply_t;

  // Tracks the list contents and the replies still owed by the block
  class list_checker;
    logic [VAL_W-1:0] entries [DEPTH];
    int               entry_count;
    list_reply_t      owed_replies [$];
    int               fails;

    function new();
      entry_count = 0;
      fails = 0;
    endfunction

    function void insert_entry(int p, logic [VAL_W-1:0] val);
      for (int i = entry_count; i >= p; i--) entries[i] = entries[i-1];
      entries[p-1] = val;
      entry_count++;
    endfunction

    // Apply one accepted operation and queue the reply it must produce
    function void note_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                          logic [VAL_W-1:0] val);
      list_reply_t r;
      bit          is_empty;
      bit          is_full;
      bit          pos_ok;
      int          w;
      r.status = ST_OK;
      r.read_value = '0;
      r.found_pos = '0;
      is_empty = (entry_count == 0);
      is_full = (entry_count >= DEPTH);
      pos_ok = (pos >= 1) && (pos <= entry_count);
      case (act)
        ACT_INS_AT: begin
          if (is_full) r.status = ST_FULL;
          else if (is_empty) insert_entry(1, val);
          else if (!pos_ok) r.status = ST_RANGE;
          else insert_entry(int'(pos), val);
        end
        ACT_INS_FIRST: begin
          if (is_full) r.status = ST_FULL;
          else insert_entry(1, val);
        end
        ACT_INS_LAST: begin
          if (is_full) r.status = ST_FULL;
          else insert_entry(entry_count + 1, val);
        end
        ACT_RM_AT: begin
          if (is_empty) r.status = ST_EMPTY;
          else if (!pos_ok) r.status = ST_RANGE;
          else begin
            for (int i = pos; i < entry_count; i++) entries[i-1] = entries[i];
            entry_count--;
          end
        end
        ACT_MODIFY: begin
          if (is_empty) r.status = ST_EMPTY;
          else if (!pos_ok) r.status = ST_RANGE;
          else entries[pos-1] = val;
        end
        ACT_READ: begin
          if (is_empty) r.status = ST_EMPTY;
          else if (!pos_ok) r.status = ST_RANGE;
          else r.read_value = entries[pos-1];
        end
        ACT_LOCATE: begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] == val) begin
              r.status = ST_OK;
              r.found_pos = POS_W'(i + 1);
              break;
            end
          end
        end
        ACT_RM_VALUE: begin
          // compact the list, dropping every match
          w = 0;
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] != val) begin
              entries[w] = entries[i];
              w++;
            end
          end
          entry_count = w;
        end
        ACT_CLEAR: entry_count = 0;
        ACT_FIRST: begin
          if (is_empty) r.status = ST_EMPTY;
          else r.found_pos = POS_W'(1);
        end
        ACT_LAST: begin
          if (is_empty) r.status = ST_EMPTY;
          else r.found_pos = POS_W'(entry_count);
        end
        ACT_NEXT: begin
          if (is_empty) r.status = ST_EMPTY;
          else if (pos == entry_count) r.status = ST_NOADJ;
          else if (!pos_ok) r.status = ST_RANGE;
          else r.found_pos = POS_W'(pos + 1);
        end
        ACT_PREV: begin
          if (is_empty) r.status = ST_EMPTY;
          else if (pos == 1) r.status = ST_NOADJ;
          else if (!pos_ok) r.status = ST_RANGE;
          else r.found_pos = POS_W'(pos - 1);
        end
        default: ;
      endcase
      r.list_len = POS_W'(entry_count);
      owed_replies.push_back(r);
    endfunction

    function void check_field(string name, logic [VAL_W-1:0] exp_v,
                              logic [VAL_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        fails++;
      end
    endfunction

    // Compare one result transaction with the oldest owed reply
    function void check_reply(logic [OUT_W-1:0] data);
      list_reply_t r;
      if (owed_replies.size() == 0) begin
        $error("result transaction with no operation pending: 0x%0h", data);
        fails++;
        return;
      end
      r = owed_replies.pop_front();
      check_field("status", VAL_W'(r.status), VAL_W'(data[ST_W-1:0]));
      check_field("read_value", r.read_value, data[OUT_RD_LSB +: VAL_W]);
      check_field("found_position", VAL_W'(r.found_pos),
                  VAL_W'(data[OUT_FP_LSB +: POS_W]));
      check_field("list_length", VAL_W'(r.list_len),
                  VAL_W'(data[OUT_LEN_LSB +: POS_W]));
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  list_checker      tracker = new();
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               op_index = 0;
  logic [VAL_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                       32'h1, 32'h5a5a_a5a5, 32'h0000_0042, 32'hdead_0001};

  array_backed_position_list uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side at random
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_reply(m_tdata);
  end

  // Offer one operation after a random gap and hold it until accepted
  task automatic send_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                         logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({val, pos, act});
    do @(posedge clk); while (!s_tready);
    tracker.note_op(act, pos, val);
  endtask

  // Random operations; the mix swings between filling, mixed use and draining
  task automatic send_random_ops(int n);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               mode;
    int               ins_pct;
    int               rm_pct;
    int               pick;
    for (int k = 0; k < n; k++) begin
      mode = (op_index / 120) % 3;
      ins_pct = (mode == 0) ? 65 : (mode == 1) ? 35 : 10;
      rm_pct = (mode == 0) ? 8 : (mode == 1) ? 20 : 45;
      pick = $urandom_range(99);
      if (pick < ins_pct) begin
        act = ACT_W'($urandom_range(ACT_INS_LAST, ACT_INS_AT));
      end else if (pick < ins_pct + rm_pct) begin
        act = ($urandom_range(3) == 0) ? ACT_RM_VALUE : ACT_RM_AT;
      end else begin
        act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_MODIFY));
        // keep clears rare so the list gets deep
        if (act == ACT_CLEAR && $urandom_range(7) != 0) act = ACT_READ;
      end
      case ($urandom_range(9))
        0:       pos = POS_W'($urandom_range(127));
        1:       pos = POS_W'(tracker.entry_count);
        2:       pos = POS_W'(1);
        default: pos = POS_W'($urandom_range(tracker.entry_count + 1));
      endcase
      if ($urandom_range(99) < 60) val = value_pool[$urandom_range(7)];
      else val = $urandom;
      send_op(act, pos, val);
      op_index++;
    end
  endtask

  initial begin
    #12ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, extremes, every action, edge positions
    send_op(ACT_READ, 7'd1, 32'h0);
    send_op(ACT_LOCATE, 7'd0, 32'h0);
    send_op(ACT_NEXT, 7'd1, 32'h0);
    send_op(ACT_FIRST, 7'd0, 32'h0);
    send_op(ACT_INS_AT, 7'd99, 32'h7fff_ffff);
    send_op(ACT_INS_FIRST, 7'd0, 32'h8000_0000);
    send_op(ACT_INS_LAST, 7'd127, 32'h0);
    send_op(ACT_INS_LAST, 7'd0, 32'hffff_ffff);
    send_op(ACT_INS_AT, 7'd2, 32'h1234_5678);
    send_op(ACT_READ, 7'd0, 32'h0);
    send_op(ACT_READ, 7'd127, 32'h0);
    send_op(ACT_READ, 7'd5, 32'h0);
    send_op(ACT_MODIFY, 7'd3, 32'h8000_0000);
    send_op(ACT_LOCATE, 7'd0, 32'h8000_0000);
    send_op(ACT_NEXT, 7'd5, 32'h0);
    send_op(ACT_PREV, 7'd1, 32'h0);
    send_op(ACT_NEXT, 7'd6, 32'h0);
    send_op(ACT_PREV, 7'd3, 32'h0);
    send_op(ACT_FIRST, 7'd0, 32'h0);
    send_op(ACT_LAST, 7'd0, 32'h0);
    send_op(ACT_RM_VALUE, 7'd0, 32'h8000_0000);
    send_op(ACT_RM_AT, 7'd0, 32'h0);
    send_op(ACT_RM_AT, 7'd1, 32'h0);
    send_op(ACT_SPARE_LO, 7'd1, 32'h0);
    send_op(ACT_SPARE_HI, 7'd127, 32'hffff_ffff);
    send_op(ACT_CLEAR, 7'd0, 32'h0);
    send_op(ACT_RM_VALUE, 7'd0, 32'h0);

    // Random phases with different idling on each side
    idle_pct = 0;  stall_pct = 0;  send_random_ops(220);
    idle_pct = 86; stall_pct = 0;  send_random_ops(220);
    idle_pct = 0;  stall_pct = 86; send_random_ops(220);
    idle_pct = 11; stall_pct = 11; send_random_ops(220);
    s_tvalid <= 1'b0;

    // Drain, then watch for stray results
    while (tracker.owed_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- array_backed_position_list.f -----
hw/rtl/apbl_pkg.sv
hw/rtl/apbl_ctrl.sv
hw/rtl/apbl_dpath.sv
hw/rtl/array_backed_position_list.sv
tb/sv/testbench.sv
